// File: hdl/jtss_pkg.sv
// Shared types, codes and helpers for the JTAG TAP shift sequencer.
`default_nettype none
package jtss_pkg;

    localparam int BURST_MAX = 7;
    localparam int CNT_W     = 3;
    localparam int WORD_W    = 32;
    localparam int LEFT_W    = 6;

    localparam logic [2:0] REQ_TAP_RESET = 3'd0;
    localparam logic [2:0] REQ_IR8       = 3'd1;
    localparam logic [2:0] REQ_DR16      = 3'd2;
    localparam logic [2:0] REQ_DR20      = 3'd3;
    localparam logic [2:0] REQ_DR32      = 3'd4;
    localparam logic [2:0] REQ_TDO       = 3'd5;

    localparam logic [1:0] LEN_8  = 2'd0;
    localparam logic [1:0] LEN_16 = 2'd1;
    localparam logic [1:0] LEN_20 = 2'd2;
    localparam logic [1:0] LEN_32 = 2'd3;

    // One command's wire cycles, beat 0 in bit 0; word fields belong to the final beat.
    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [BURST_MAX-1:0] tms;
        logic [BURST_MAX-1:0] tdi;
        logic [BURST_MAX-1:0] want;
        logic                 word_valid;
        logic [WORD_W-1:0]    word;
        logic                 err;
    } burst_t;

    function automatic logic [LEFT_W-1:0] len_of(input logic [1:0] lc);
        case (lc)
            LEN_8:   len_of = 6'd8;
            LEN_16:  len_of = 6'd16;
            LEN_20:  len_of = 6'd20;
            default: len_of = 6'd32;
        endcase
    endfunction

    function automatic logic msb_bit(input logic [WORD_W-1:0] d, input logic [1:0] lc);
        case (lc)
            LEN_8:   msb_bit = d[7];
            LEN_16:  msb_bit = d[15];
            LEN_20:  msb_bit = d[19];
            default: msb_bit = d[31];
        endcase
    endfunction

endpackage
`default_nettype wire

// File: hdl/jtag_tap_shift_sequencer_unit.sv
// Top level of the JTAG TAP shift sequencer.
`default_nettype none
// Each accepted command becomes a burst of wire cycles (TMS/TDI pairs) on the result
// channel, one transfer per clock while m_ready is high: 7 for a TAP reset, 5 to start an
// IR shift, 4 to start a DR shift, 1 for each returned TDO bit in mid-shift, 2 for the exit
// with the captured word, and 1 for a flagged protocol error. The result port is the only
// limit: the next command is taken in the same cycle as the final beat of the current
// burst, so a command holds the block only while its burst plays out, and a TDO return
// that answers a single shift cycle follows it with no gap. The sequencer state advances
// when the command is taken, so commands queue behind the burst in order.
module jtag_tap_shift_sequencer_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [2:0]                  s_req_type,
    input  wire logic [jtss_pkg::WORD_W-1:0] s_shift_data,
    input  wire logic                        s_tclk_level,
    input  wire logic                        s_tdo_bit,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_tms,
    output logic                             m_tdi,
    output logic                             m_wants_tdo,
    output logic                             m_word_valid,
    output logic [jtss_pkg::WORD_W-1:0]      m_captured_word,
    output logic                             m_protocol_error,
    output logic                             m_last
);
    import jtss_pkg::*;

    burst_t burst;
    logic   can_load;
    logic   load;

    assign s_ready = can_load;
    assign load    = s_valid && can_load;

    jtss_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .req_type   (s_req_type),
        .shift_data (s_shift_data),
        .tclk_level (s_tclk_level),
        .tdo_bit    (s_tdo_bit),
        .burst      (burst)
    );

    jtss_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .burst            (burst),
        .can_load         (can_load),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tms            (m_tms),
        .m_tdi            (m_tdi),
        .m_wants_tdo      (m_wants_tdo),
        .m_word_valid     (m_word_valid),
        .m_captured_word  (m_captured_word),
        .m_protocol_error (m_protocol_error),
        .m_last           (m_last)
    );

endmodule
`default_nettype wire

// File: hdl/jtss_ctrl.sv
// Sequencer state and command decode into a burst of wire cycles.
`default_nettype none
module jtss_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [2:0]                 req_type,
    input  wire logic [jtss_pkg::WORD_W-1:0] shift_data,
    input  wire logic                       tclk_level,
    input  wire logic                       tdo_bit,
    output jtss_pkg::burst_t                burst
);
    import jtss_pkg::*;

    logic              shifting_reg, shifting_next;
    logic [LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic [WORD_W-1:0] out_shifter_reg, out_shifter_next;
    logic [WORD_W-1:0] in_word_reg, in_word_next;
    logic [1:0]        length_code_reg, length_code_next;
    logic              saved_tclk_reg, saved_tclk_next;

    always_comb begin
        logic [1:0]        lc;
        logic              bit_out;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] shifted_in;

        shifting_next    = shifting_reg;
        bits_left_next   = bits_left_reg;
        out_shifter_next = out_shifter_reg;
        in_word_next     = in_word_reg;
        length_code_next = length_code_reg;
        saved_tclk_next  = saved_tclk_reg;

        burst            = '0;
        lc               = 2'(req_type - REQ_IR8);
        bit_out          = 1'b0;
        w                = '0;
        shifted_in       = {in_word_reg[WORD_W-2:0], tdo_bit};

        if (req_type > REQ_TDO || ((req_type == REQ_TDO) != shifting_reg)) begin
            // unexpected input: drop it, flag one non-wire result
            burst.count = 3'd1;
            burst.err   = 1'b1;
        end else if (req_type == REQ_TAP_RESET) begin
            burst.count = 3'd7;
            burst.tms   = 7'b0111111;
            burst.tdi   = 7'b1111111;
        end else if (req_type == REQ_TDO) begin
            in_word_next = shifted_in;
            if (bits_left_reg != '0) begin
                bit_out          = msb_bit(out_shifter_reg, length_code_reg);
                out_shifter_next = {out_shifter_reg[WORD_W-2:0], 1'b0};
                bits_left_next   = bits_left_reg - 6'd1;
                burst.count      = 3'd1;
                burst.tms        = {6'b0, (bits_left_reg == 6'd1)};
                burst.tdi        = {6'b0, bit_out};
                burst.want       = 7'b0000001;
            end else begin
                case (length_code_reg)
                    LEN_8:   w = {24'b0, shifted_in[7:0]};
                    LEN_16:  w = {16'b0, shifted_in[15:0]};
                    LEN_20:  w = {12'b0, shifted_in[3:0], shifted_in[19:4]};
                    default: w = shifted_in;
                endcase
                shifting_next    = 1'b0;
                burst.count      = 3'd2;
                burst.tms        = 7'b0000001;
                burst.tdi        = {5'b0, saved_tclk_reg, 1'b1};
                burst.word_valid = 1'b1;
                burst.word       = w;
            end
        end else begin
            bit_out          = msb_bit(shift_data, lc);
            length_code_next = lc;
            bits_left_next   = len_of(lc) - 6'd1;
            out_shifter_next = {shift_data[WORD_W-2:0], 1'b0};
            in_word_next     = '0;
            saved_tclk_next  = tclk_level;
            shifting_next    = 1'b1;
            if (req_type == REQ_IR8) begin
                burst.count = 3'd5;
                burst.tms   = 7'b0000011;
                burst.tdi   = {2'b0, bit_out, 3'b111, tclk_level};
                burst.want  = 7'b0010000;
            end else begin
                burst.count = 3'd4;
                burst.tms   = 7'b0000001;
                burst.tdi   = {3'b0, bit_out, 2'b11, tclk_level};
                burst.want  = 7'b0001000;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shifting_reg    <= 1'b0;
            bits_left_reg   <= '0;
            out_shifter_reg <= '0;
            in_word_reg     <= '0;
            length_code_reg <= LEN_8;
            saved_tclk_reg  <= 1'b0;
        end else if (load) begin
            shifting_reg    <= shifting_next;
            bits_left_reg   <= bits_left_next;
            out_shifter_reg <= out_shifter_next;
            in_word_reg     <= in_word_next;
            length_code_reg <= length_code_next;
            saved_tclk_reg  <= saved_tclk_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jtss_emit.sv
// Result buffer that plays out one burst of wire cycles, one transfer per beat.
`default_nettype none
module jtss_emit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire jtss_pkg::burst_t            burst,
    output logic                             can_load,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_tms,
    output logic                             m_tdi,
    output logic                             m_wants_tdo,
    output logic                             m_word_valid,
    output logic [jtss_pkg::WORD_W-1:0]      m_captured_word,
    output logic                             m_protocol_error,
    output logic                             m_last
);
    import jtss_pkg::*;

    logic [CNT_W-1:0]     cnt_reg;
    logic [BURST_MAX-1:0] tms_reg, tdi_reg, want_reg;
    logic                 valid_reg, err_reg;
    logic [WORD_W-1:0]    word_reg;
    logic                 take;

    assign m_valid  = (cnt_reg != '0);
    assign m_last   = (cnt_reg == 3'd1);
    assign take     = m_valid && m_ready;
    // refill when idle or on the cycle the final beat is taken
    assign can_load = !m_valid || (take && m_last);

    assign m_tms            = tms_reg[0];
    assign m_tdi            = tdi_reg[0];
    assign m_wants_tdo      = want_reg[0];
    assign m_word_valid     = m_last && valid_reg;
    assign m_captured_word  = m_last ? word_reg : '0;
    assign m_protocol_error = m_last && err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst.count;
        end else if (take) begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tms_reg   <= burst.tms;
            tdi_reg   <= burst.tdi;
            want_reg  <= burst.want;
            valid_reg <= burst.word_valid;
            word_reg  <= burst.word;
            err_reg   <= burst.err;
        end else if (take) begin
            tms_reg  <= {1'b0, tms_reg[BURST_MAX-1:1]};
            tdi_reg  <= {1'b0, tdi_reg[BURST_MAX-1:1]};
            want_reg <= {1'b0, want_reg[BURST_MAX-1:1]};
        end
    end

endmodule
`default_nettype wire

// File: hdl/jtss_checker.sv
// Port-level checker for the JTAG TAP shift sequencer, bound to the top level.
`default_nettype none
module jtss_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_tms,
    input wire logic        m_tdi,
    input wire logic        m_wants_tdo,
    input wire logic        m_word_valid,
    input wire logic [31:0] m_captured_word,
    input wire logic        m_protocol_error,
    input wire logic        m_last
);

    // hold a stalled transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tms) && $stable(m_tdi)
            && $stable(m_last) && $stable(m_captured_word))
        else $error("stalled result changed");

    a_word_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word_valid |-> m_last && !m_wants_tdo && !m_tms)
        else $error("captured word not on final exit cycle");

    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_protocol_error |-> m_last && !m_tms && !m_tdi && !m_wants_tdo
            && !m_word_valid)
        else $error("error result carries wire levels");

    a_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word_valid |-> m_captured_word == 32'd0)
        else $error("captured word leaks outside exit cycle");

    a_tdo_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wants_tdo |-> m_last)
        else $error("shift cycle is not the final result of its command");

endmodule

bind jtag_tap_shift_sequencer_unit jtss_checker u_jtss_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_tms            (m_tms),
    .m_tdi            (m_tdi),
    .m_wants_tdo      (m_wants_tdo),
    .m_word_valid     (m_word_valid),
    .m_captured_word  (m_captured_word),
    .m_protocol_error (m_protocol_error),
    .m_last           (m_last)
);
`default_nettype wire
